[sv/blg_pkg.sv]
// shared constants, types and helpers for the bresenham line generator
// no dependencies; compiled first
package blg_pkg;

    localparam int COORD_BITS = 11;
    localparam int PITCH_BITS = 12;
    localparam int INDEX_BITS = 22;
    localparam int COLOR_BITS = 24;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int PROD_BITS  = COORD_BITS + PITCH_BITS;

    localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(1024);

    typedef logic [COORD_BITS-1:0]    t_coord;
    typedef logic [PITCH_BITS-1:0]    t_pitch;
    typedef logic [INDEX_BITS-1:0]    t_index;
    typedef logic [COLOR_BITS-1:0]    t_color;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    // one unit step along an axis, wrapping within the coordinate width
    function automatic t_coord step_coord(input t_coord v, input logic neg);
        t_coord one;
        one = t_coord'(1);
        return neg ? (v - one) : (v + one);
    endfunction

endpackage

[sv/blg_channels.sv]
// valid/ready channel interfaces: command input, pixel output, pitch write
// depends on blg_pkg
interface blg_in_if import blg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_coord x_start;
    t_coord y_start;
    t_coord x_end;
    t_coord y_end;
    t_color pen_color;

    modport source (output valid, cmd, x_start, y_start, x_end, y_end, pen_color,
                    input ready);
    modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, pen_color,
                    output ready);
endinterface

interface blg_out_if import blg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord px;
    t_coord py;
    t_index pixel_index;
    t_color out_color;
    logic   last;

    modport source (output valid, px, py, pixel_index, out_color, last, input ready);
    modport sink   (input valid, px, py, pixel_index, out_color, last, output ready);
endinterface

interface blg_cfg_if import blg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pitch line_pitch;

    modport source (output valid, line_pitch, input ready);
    modport sink   (input valid, line_pitch, output ready);
endinterface

[sv/bresenham_line_generator_core.sv]
// bresenham line generator: line set-up and one pixel per step transfer
// depends on blg_pkg and the channel interfaces in blg_channels.sv
//
// usage
//   i_in carries commands. a start transfer (cmd = start) loads both
//   endpoints and the pen color and produces no pixel. each step transfer
//   (cmd = step) while a line is in progress produces one pixel on o_out;
//   a step with no line in progress is taken and dropped. a line of major
//   axis length n gives n+1 pixels, the final one with last set.
//   a start in the middle of a line abandons it and begins the new one.
//   i_cfg writes line_pitch (pixels per row) and is always ready; write it
//   only while no pixel is pending.
// timing
//   a pixel appears on o_out in the cycle after its step transfer. one
//   item is taken every cycle unless o_out stalls: the next pixel's error
//   term and coordinates come from a single add/compare pass on the line
//   registers, and the word index from one 11x12 multiply plus add ahead of the output register.
// reset and stall
//   i_rst_n is synchronous, active low: no line in progress, no pixel
//   pending, line_pitch back to 1024. when o_out stalls, the pixel holds in
//   the output register and i_in takes a new item in the cycle the pixel
//   is taken (ready = output register empty or being drained).
module bresenham_line_generator_core import blg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    blg_in_if.sink    i_in,
    blg_out_if.source o_out,
    blg_cfg_if.sink   i_cfg
);

    // line state
    t_coord r_cur_x, r_cur_y;
    t_coord r_abs_dx, r_abs_dy;
    t_err   r_err;
    logic   r_x_neg, r_y_neg, r_x_major;
    t_coord r_remaining;
    logic   r_active;
    t_color r_held_color;
    t_pitch r_line_pitch;

    // output register
    logic   r_out_valid;
    t_coord r_px, r_py;
    t_index r_pixel_index;
    t_color r_out_color;
    logic   r_last;

    logic in_xfer, is_start, step_fire, is_last;

    // start set-up
    logic   s_x_neg, s_y_neg, s_x_major;
    t_coord s_adx, s_ady, s_major, s_minor;
    t_err   s_err;

    // step advance
    t_coord   major, minor;
    logic     err_pos;
    t_err     n_err;
    t_coord   n_cur_x, n_cur_y;
    logic [PROD_BITS-1:0] prod, idx_sum;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign is_start  = (i_in.cmd == CMD_START);
    assign step_fire = in_xfer && !is_start && r_active;
    assign is_last   = (r_remaining == '0);

    // deltas, step signs, major axis and initial error
    always_comb begin
        s_x_neg   = i_in.x_end < i_in.x_start;
        s_y_neg   = i_in.y_end < i_in.y_start;
        s_adx     = s_x_neg ? (i_in.x_start - i_in.x_end) : (i_in.x_end - i_in.x_start);
        s_ady     = s_y_neg ? (i_in.y_start - i_in.y_end) : (i_in.y_end - i_in.y_start);
        s_x_major = s_adx >= s_ady;
        s_major   = s_x_major ? s_adx : s_ady;
        s_minor   = s_x_major ? s_ady : s_adx;
        // minor - major/2, halving truncated
        s_err     = $signed({2'b00, s_minor}) - $signed({3'b000, s_major[COORD_BITS-1:1]});
    end

    // next error term and coordinates for one step
    always_comb begin
        major   = r_x_major ? r_abs_dx : r_abs_dy;
        minor   = r_x_major ? r_abs_dy : r_abs_dx;
        err_pos = (r_err > $signed(t_err'(0)));
        n_err   = r_err + $signed({2'b00, minor})
                  - (err_pos ? $signed({2'b00, major}) : $signed(t_err'(0)));
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (r_x_major) begin
            n_cur_x = step_coord(r_cur_x, r_x_neg);
            if (err_pos) begin
                n_cur_y = step_coord(r_cur_y, r_y_neg);
            end
        end else begin
            n_cur_y = step_coord(r_cur_y, r_y_neg);
            if (err_pos) begin
                n_cur_x = step_coord(r_cur_x, r_x_neg);
            end
        end
    end

    // framebuffer word index, wraps to its field width
    always_comb begin
        prod    = r_cur_y * r_line_pitch;
        idx_sum = prod + PROD_BITS'(r_cur_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_remaining  <= '0;
            r_out_valid  <= 1'b0;
            r_line_pitch <= PITCH_RESET;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_abs_dx     <= '0;
            r_abs_dy     <= '0;
            r_err        <= '0;
            r_x_neg      <= 1'b0;
            r_y_neg      <= 1'b0;
            r_x_major    <= 1'b0;
            r_held_color <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_line_pitch <= i_cfg.line_pitch;
            end

            if (in_xfer && is_start) begin
                r_x_neg      <= s_x_neg;
                r_y_neg      <= s_y_neg;
                r_abs_dx     <= s_adx;
                r_abs_dy     <= s_ady;
                r_x_major    <= s_x_major;
                r_err        <= s_err;
                r_cur_x      <= i_in.x_start;
                r_cur_y      <= i_in.y_start;
                r_remaining  <= s_major;
                r_held_color <= i_in.pen_color;
                r_active     <= 1'b1;
            end else if (step_fire) begin
                if (is_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_remaining <= r_remaining - t_coord'(1);
                    r_err       <= n_err;
                    r_cur_x     <= n_cur_x;
                    r_cur_y     <= n_cur_y;
                end
            end

            if (step_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pixel payload, loaded on each step transfer
    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_px          <= r_cur_x;
            r_py          <= r_cur_y;
            r_pixel_index <= idx_sum[INDEX_BITS-1:0];
            r_out_color   <= r_held_color;
            r_last        <= is_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.px          = r_px;
    assign o_out.py          = r_py;
    assign o_out.pixel_index = r_pixel_index;
    assign o_out.out_color   = r_out_color;
    assign o_out.last        = r_last;

    // a new pixel only ever follows a step taken during a line
    a_pixel_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step_fire))
        else $error("pixel appeared without a step transfer");

    // the final pixel ends the line
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && is_last |=> !r_active)
        else $error("line still active after its final pixel");

    // an idle generator has no pixels left to count
    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_remaining == '0))
        else $error("pixel count nonzero while idle");

endmodule
